// ----- design/dmx_pkg.sv -----
package dmx_pkg;

  // field widths
  localparam int unsigned ActionW  = 3;
  localparam int unsigned SlotW    = 10;
  localparam int unsigned ByteW    = 8;
  localparam int unsigned LenW     = 10;
  localparam int unsigned ModeW    = 3;
  localparam int unsigned TimActW  = 2;
  localparam int unsigned TimeW    = 20;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 20;

  // stream word widths
  localparam int unsigned InDataW  = 32;
  localparam int unsigned InUserW  = 4;
  localparam int unsigned OutDataW = 56;

  localparam int unsigned SlotCountDef = 512;

  // host and line actions
  localparam logic [ActionW-1:0] ActWrSlot  = 3'd0;
  localparam logic [ActionW-1:0] ActRdSlot  = 3'd1;
  localparam logic [ActionW-1:0] ActTxStart = 3'd2;
  localparam logic [ActionW-1:0] ActTxEvent = 3'd3;
  localparam logic [ActionW-1:0] ActRxStart = 3'd4;
  localparam logic [ActionW-1:0] ActRxByte  = 3'd5;
  localparam logic [ActionW-1:0] ActRxTmo   = 3'd6;
  localparam logic [ActionW-1:0] ActStop    = 3'd7;

  // link modes
  localparam logic [ModeW-1:0] ModeIdle  = 3'd0;
  localparam logic [ModeW-1:0] ModeBreak = 3'd1;
  localparam logic [ModeW-1:0] ModeMab   = 3'd2;
  localparam logic [ModeW-1:0] ModeData  = 3'd3;
  localparam logic [ModeW-1:0] ModeMbb   = 3'd4;
  localparam logic [ModeW-1:0] ModePause = 3'd5;
  localparam logic [ModeW-1:0] ModeRecv  = 3'd6;

  // timer commands
  localparam logic [TimActW-1:0] TimNone = 2'd0;
  localparam logic [TimActW-1:0] TimLoad = 2'd1;
  localparam logic [TimActW-1:0] TimStop = 2'd2;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgStartCode = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgMinFrame  = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgBreak     = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgMab       = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgMbb       = 3'd4;
  localparam logic [CfgIdxW-1:0] CfgRxTmo     = 3'd5;

  // configuration reset values
  localparam logic [ByteW-1:0] StartCodeRst = 8'd0;
  localparam logic [LenW-1:0]  MinFrameRst  = 10'd25;
  localparam logic [TimeW-1:0] BreakRst     = 20'd100;
  localparam logic [TimeW-1:0] MabRst       = 20'd12;
  localparam logic [TimeW-1:0] MbbRst       = 20'd0;
  localparam logic [TimeW-1:0] RxTmoRst     = 20'd1000;

  // result before the buffer read data is merged in
  typedef struct packed {
    logic [ModeW-1:0]   mode;
    logic               tx_valid;
    logic               rd_valid;
    logic [TimActW-1:0] tim_act;
    logic [TimeW-1:0]   tim_val;
    logic               done;
    logic [LenW-1:0]    size;
  } stage_t;

endpackage

// ----- design/dmx512_frame_tx_rx_controller_top.sv -----
// An accepted word goes to m_axis via two register stages: stage 1 and the output register.
// Throughput: one word per cycle while m_axis is not stalled; the slot buffer has one write
// and one read port, and each word uses at most one of them at accept.
// Reset: link idle, pointers and lengths cleared, registers to defaults.
// The slot buffer is not cleared; its contents are undefined until written.
module dmx512_frame_tx_rx_controller_top #(
  parameter int unsigned SLOT_COUNT = dmx_pkg::SlotCountDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [dmx_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dmx_pkg::CfgDataW-1:0]  cfg_data_i,
  // events in
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  // slot_index[9:0], data_byte[17:10], length[27:18], set_start_code[28], zero fill
  input  logic [dmx_pkg::InDataW-1:0]   s_axis_tdata,
  // action[2:0], byte_error[3]
  input  logic [dmx_pkg::InUserW-1:0]   s_axis_tuser,
  // results out
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // mode[2:0], drive_out[3], line_level[4], tx_valid[5], tx_data[13:6],
  // timer_action[15:14], timer_value[35:16], frame_done[36], frame_size[46:37],
  // read_data[54:47], zero fill
  output logic [dmx_pkg::OutDataW-1:0]  m_axis_tdata
);

  localparam int unsigned Depth = SLOT_COUNT + 1;
  localparam int unsigned AddrW = $clog2(Depth);
  localparam logic [dmx_pkg::SlotW-1:0] SlotMax  = dmx_pkg::SlotW'(SLOT_COUNT);
  localparam logic [dmx_pkg::LenW-1:0]  LenLimit = dmx_pkg::LenW'(SLOT_COUNT + 1);

  // unpacked input word
  logic [dmx_pkg::ActionW-1:0] action;
  logic [dmx_pkg::SlotW-1:0]   slot_index;
  logic [dmx_pkg::ByteW-1:0]   data_byte;
  logic [dmx_pkg::LenW-1:0]    length;
  logic                        set_start_code;
  logic                        byte_error;
  logic [dmx_pkg::LenW-1:0]    len_clamp;

  assign action         = s_axis_tuser[2:0];
  assign byte_error     = s_axis_tuser[3];
  assign slot_index     = s_axis_tdata[9:0];
  assign data_byte      = s_axis_tdata[17:10];
  assign length         = s_axis_tdata[27:18];
  assign set_start_code = s_axis_tdata[28];
  assign len_clamp      = (length > LenLimit) ? LenLimit : length;

  // configuration registers
  logic [dmx_pkg::ByteW-1:0] start_code_q;
  logic [dmx_pkg::LenW-1:0]  min_frame_q;
  logic [dmx_pkg::TimeW-1:0] break_time_q, mab_time_q, mbb_time_q, rx_tmo_q;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start_code_q <= dmx_pkg::StartCodeRst;
      min_frame_q  <= dmx_pkg::MinFrameRst;
      break_time_q <= dmx_pkg::BreakRst;
      mab_time_q   <= dmx_pkg::MabRst;
      mbb_time_q   <= dmx_pkg::MbbRst;
      rx_tmo_q     <= dmx_pkg::RxTmoRst;
    end else if (cfg_valid_i) begin
      unique case (cfg_index_i)
        dmx_pkg::CfgStartCode: start_code_q <= cfg_data_i[7:0];
        dmx_pkg::CfgMinFrame:  min_frame_q  <= cfg_data_i[9:0];
        dmx_pkg::CfgBreak:     break_time_q <= cfg_data_i;
        dmx_pkg::CfgMab:       mab_time_q   <= cfg_data_i;
        dmx_pkg::CfgMbb:       mbb_time_q   <= cfg_data_i;
        dmx_pkg::CfgRxTmo:     rx_tmo_q     <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // pipeline handshake
  logic s1_valid_q, out_valid_q;
  logic s1_move, accept;

  assign s1_move       = s1_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !s1_valid_q || s1_move;
  assign accept        = s_axis_tvalid && s_axis_tready;

  // link state
  logic [dmx_pkg::ModeW-1:0] mode_q, mode_d;
  logic [dmx_pkg::SlotW-1:0] ptr_q, ptr_d;
  logic [dmx_pkg::LenW-1:0]  tx_len_q, tx_len_d, rx_lim_q, rx_lim_d;

  // buffer port requests
  logic                      mem_we, mem_re;
  logic [dmx_pkg::SlotW-1:0] mem_waddr, mem_raddr;
  logic [dmx_pkg::ByteW-1:0] mem_wdata;

  dmx_pkg::stage_t st_d, st_q;

  logic [dmx_pkg::SlotW-1:0] tx_ptr, tx_ptr_inc, ptr_inc;
  logic                      rx_active, rx_end, rx_full;

  assign ptr_inc    = ptr_q + 10'd1;
  assign tx_ptr     = (mode_q == dmx_pkg::ModeMab) ? '0 : ptr_q;
  assign tx_ptr_inc = tx_ptr + 10'd1;
  assign rx_active  = (mode_q == dmx_pkg::ModePause) || (mode_q == dmx_pkg::ModeRecv);
  assign rx_end     = ((action == dmx_pkg::ActRxByte) && byte_error) ||
                      (action == dmx_pkg::ActRxTmo) || (ptr_q >= rx_lim_q);
  assign rx_full    = ptr_inc >= min_frame_q;

  always_comb begin
    mode_d    = mode_q;
    ptr_d     = ptr_q;
    tx_len_d  = tx_len_q;
    rx_lim_d  = rx_lim_q;
    mem_we    = 1'b0;
    mem_re    = 1'b0;
    mem_waddr = slot_index;
    mem_raddr = slot_index;
    mem_wdata = data_byte;
    st_d      = '0;

    unique case (action)
      dmx_pkg::ActWrSlot: begin
        mem_we = slot_index <= SlotMax;
      end
      dmx_pkg::ActRdSlot: begin
        mem_re        = slot_index <= SlotMax;
        st_d.rd_valid = mem_re;
      end
      dmx_pkg::ActTxStart: begin
        mem_we       = set_start_code;
        mem_waddr    = '0;
        mem_wdata    = start_code_q;
        tx_len_d     = len_clamp;
        mode_d       = dmx_pkg::ModeBreak;
        st_d.tim_act = dmx_pkg::TimLoad;
        st_d.tim_val = break_time_q;
      end
      dmx_pkg::ActTxEvent: begin
        unique case (mode_q)
          dmx_pkg::ModeBreak: begin
            mode_d       = dmx_pkg::ModeMab;
            st_d.tim_act = dmx_pkg::TimLoad;
            st_d.tim_val = mab_time_q;
          end
          dmx_pkg::ModeMab, dmx_pkg::ModeData: begin
            if (mode_q == dmx_pkg::ModeMab) begin
              st_d.tim_act = dmx_pkg::TimStop;
            end
            mode_d = dmx_pkg::ModeData;
            ptr_d  = tx_ptr;
            if (tx_ptr <= SlotMax) begin
              mem_re        = 1'b1;
              mem_raddr     = tx_ptr;
              st_d.tx_valid = 1'b1;
              ptr_d         = tx_ptr_inc;
            end
            if (ptr_d >= tx_len_q || ptr_d > SlotMax) begin
              mode_d = dmx_pkg::ModeMbb;
            end
          end
          dmx_pkg::ModeMbb: begin
            mode_d       = dmx_pkg::ModePause;
            st_d.tim_act = dmx_pkg::TimLoad;
            st_d.tim_val = mbb_time_q;
          end
          dmx_pkg::ModePause: begin
            st_d.tim_act = dmx_pkg::TimStop;
          end
          default: ;
        endcase
      end
      dmx_pkg::ActRxStart: begin
        rx_lim_d     = len_clamp;
        ptr_d        = '0;
        mode_d       = dmx_pkg::ModePause;
        st_d.tim_act = dmx_pkg::TimLoad;
        st_d.tim_val = rx_tmo_q;
      end
      dmx_pkg::ActRxByte, dmx_pkg::ActRxTmo: begin
        if (rx_active) begin
          if (rx_end) begin
            mode_d = dmx_pkg::ModePause;
          end else if (mode_q == dmx_pkg::ModePause) begin
            mode_d = dmx_pkg::ModeRecv;
            ptr_d  = '0;
          end else begin
            ptr_d = ptr_inc;
          end
          if (rx_end && rx_full) begin
            // complete frame: report it and drop the byte
            st_d.done = 1'b1;
            st_d.size = ptr_inc;
            ptr_d     = '0;
          end else if (!(rx_end && (action == dmx_pkg::ActRxTmo))) begin
            mem_we       = ptr_d <= SlotMax;
            mem_waddr    = ptr_d;
            st_d.tim_act = dmx_pkg::TimLoad;
            st_d.tim_val = rx_tmo_q;
          end
        end
      end
      dmx_pkg::ActStop: begin
        mode_d       = dmx_pkg::ModePause;
        st_d.tim_act = dmx_pkg::TimStop;
      end
      default: ;
    endcase
    st_d.mode = mode_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q   <= dmx_pkg::ModeIdle;
      ptr_q    <= '0;
      tx_len_q <= '0;
      rx_lim_q <= '0;
    end else if (accept) begin
      mode_q   <= mode_d;
      ptr_q    <= ptr_d;
      tx_len_q <= tx_len_d;
      rx_lim_q <= rx_lim_d;
    end
  end

  // slot buffer
  logic [dmx_pkg::ByteW-1:0] slot_mem [Depth];
  logic [dmx_pkg::ByteW-1:0] mem_rd_q;

  always_ff @(posedge clk_i) begin
    if (accept && mem_we) begin
      slot_mem[mem_waddr[AddrW-1:0]] <= mem_wdata;
    end
    if (accept && mem_re) begin
      mem_rd_q <= slot_mem[mem_raddr[AddrW-1:0]];
    end
  end

  // stage 1: waits for buffer read data
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else if (accept) begin
      s1_valid_q <= 1'b1;
    end else if (s1_move) begin
      s1_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      st_q <= st_d;
    end
  end

  // output register
  logic [dmx_pkg::OutDataW-1:0] out_d, out_q;
  logic                         drive, level;
  logic [dmx_pkg::ByteW-1:0]    tx_byte, rd_byte;

  assign drive   = (st_q.mode == dmx_pkg::ModeBreak) || (st_q.mode == dmx_pkg::ModeMab) ||
                   (st_q.mode == dmx_pkg::ModeData) || (st_q.mode == dmx_pkg::ModeMbb);
  assign level   = st_q.mode != dmx_pkg::ModeBreak;
  assign tx_byte = st_q.tx_valid ? mem_rd_q : '0;
  assign rd_byte = st_q.rd_valid ? mem_rd_q : '0;
  assign out_d   = {1'b0, rd_byte, st_q.size, st_q.done, st_q.tim_val, st_q.tim_act,
                    tx_byte, st_q.tx_valid, level, drive, st_q.mode};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (s1_move) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_move) begin
      out_q <= out_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_q;

`ifndef SYNTHESIS
  a_ptr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    ptr_q <= LenLimit)
    else $error("slot pointer beyond buffer end");

  a_one_port: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> !(mem_we && mem_re))
    else $error("buffer read and write in one word");

  a_tx_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && st_q.tx_valid) |->
      (st_q.mode == dmx_pkg::ModeData || st_q.mode == dmx_pkg::ModeMbb))
    else $error("byte sent outside data phase");

  a_done_pause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && st_q.done) |->
      (st_q.mode == dmx_pkg::ModePause && st_q.size != '0 &&
       st_q.tim_act == dmx_pkg::TimNone))
    else $error("frame report inconsistent");

  a_full_stall: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_valid_q && out_valid_q && !m_axis_tready) |=> s1_valid_q && out_valid_q)
    else $error("result lost while stalled");
`endif

endmodule

// ----- sim/tb.sv -----
`timescale 1ns / 100ps

module tb;

  localparam int unsigned ClkPeriod   = 12;
  localparam int unsigned ResetCycles = 12;
  localparam int unsigned CycleLimit  = 200000;
  // no register lives at this index; a write to it must change nothing
  localparam logic [dmx_pkg::CfgIdxW-1:0] CfgSpare = 3'd6;

  typedef struct packed {
    logic [dmx_pkg::ActionW-1:0] action;
    logic [dmx_pkg::SlotW-1:0]   slot;
    logic [dmx_pkg::ByteW-1:0]   data;
    logic [dmx_pkg::LenW-1:0]    len;
    logic                        set_sc;
    logic                        berr;
  } link_event_t;

  // laid out to match m_axis_tdata, top bit is the zero fill
  typedef struct packed {
    logic                        zero_fill;
    logic [dmx_pkg::ByteW-1:0]   read_data;
    logic [dmx_pkg::LenW-1:0]    frame_size;
    logic                        frame_done;
    logic [dmx_pkg::TimeW-1:0]   timer_value;
    logic [dmx_pkg::TimActW-1:0] timer_action;
    logic [dmx_pkg::ByteW-1:0]   tx_data;
    logic                        tx_valid;
    logic                        line_level;
    logic                        drive_out;
    logic [dmx_pkg::ModeW-1:0]   mode;
  } link_result_t;

  logic                         clk_i;
  logic                         rst_ni;
  logic                         cfg_valid_i;
  logic                         cfg_ready_o;
  logic [dmx_pkg::CfgIdxW-1:0]  cfg_index_i;
  logic [dmx_pkg::CfgDataW-1:0] cfg_data_i;
  logic                         s_axis_tvalid;
  logic                         s_axis_tready;
  logic [dmx_pkg::InDataW-1:0]  s_axis_tdata;
  logic [dmx_pkg::InUserW-1:0]  s_axis_tuser;
  logic                         m_axis_tvalid;
  logic                         m_axis_tready;
  logic [dmx_pkg::OutDataW-1:0] m_axis_tdata;

  dmx512_frame_tx_rx_controller_top u_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  // link state as the block should hold it
  logic [dmx_pkg::ByteW-1:0] sc_reg      = dmx_pkg::StartCodeRst;
  logic [dmx_pkg::LenW-1:0]  minf_reg    = dmx_pkg::MinFrameRst;
  logic [dmx_pkg::TimeW-1:0] brk_ticks   = dmx_pkg::BreakRst;
  logic [dmx_pkg::TimeW-1:0] mab_ticks   = dmx_pkg::MabRst;
  logic [dmx_pkg::TimeW-1:0] mbb_ticks   = dmx_pkg::MbbRst;
  logic [dmx_pkg::TimeW-1:0] rxtmo_ticks = dmx_pkg::RxTmoRst;
  logic [dmx_pkg::ModeW-1:0] lk_mode     = dmx_pkg::ModeIdle;
  int unsigned               lk_ptr      = 0;
  int unsigned               lk_txlen    = 0;
  int unsigned               lk_rxlim    = 0;
  logic [dmx_pkg::ByteW-1:0] slot_mem [0:dmx_pkg::SlotCountDef];

  link_event_t  pend_q [$];
  link_result_t link_exp_q [$];
  link_event_t  in_cur;
  logic         s_fire;
  int unsigned  in_gap;
  int unsigned  out_gap;
  bit           calm;
  int unsigned  mismatches;
  int unsigned  cycles;
  int unsigned  queued;

  function automatic int unsigned clamp_len(logic [dmx_pkg::LenW-1:0] len);
    return (len > dmx_pkg::SlotCountDef + 1) ? dmx_pkg::SlotCountDef + 1 : len;
  endfunction

  function automatic link_result_t link_step(link_event_t ev);
    link_result_t                r;
    logic [dmx_pkg::TimActW-1:0] tact;
    logic [dmx_pkg::TimeW-1:0]   tval;
    bit                          keep;
    r    = '0;
    tact = dmx_pkg::TimNone;
    tval = '0;
    keep = 1'b0;
    case (ev.action)
      dmx_pkg::ActWrSlot: if (ev.slot <= dmx_pkg::SlotCountDef) slot_mem[ev.slot] = ev.data;
      dmx_pkg::ActRdSlot: if (ev.slot <= dmx_pkg::SlotCountDef) r.read_data = slot_mem[ev.slot];
      dmx_pkg::ActTxStart: begin
        if (ev.set_sc) slot_mem[0] = sc_reg;
        lk_txlen = clamp_len(ev.len);
        lk_mode  = dmx_pkg::ModeBreak;
        tact     = dmx_pkg::TimLoad;
        tval     = brk_ticks;
      end
      dmx_pkg::ActTxEvent: begin
        if (lk_mode == dmx_pkg::ModeBreak) begin
          lk_mode = dmx_pkg::ModeMab;
          tact    = dmx_pkg::TimLoad;
          tval    = mab_ticks;
        end else if (lk_mode == dmx_pkg::ModeMab || lk_mode == dmx_pkg::ModeData) begin
          if (lk_mode == dmx_pkg::ModeMab) begin
            tact    = dmx_pkg::TimStop;
            lk_ptr  = 0;
            lk_mode = dmx_pkg::ModeData;
          end
          if (lk_ptr <= dmx_pkg::SlotCountDef) begin
            r.tx_valid = 1'b1;
            r.tx_data  = slot_mem[lk_ptr];
            lk_ptr++;
          end
          // a zero length still sends one byte
          if (lk_ptr >= lk_txlen || lk_ptr > dmx_pkg::SlotCountDef) lk_mode = dmx_pkg::ModeMbb;
        end else if (lk_mode == dmx_pkg::ModeMbb) begin
          tact    = dmx_pkg::TimLoad;
          tval    = mbb_ticks;
          lk_mode = dmx_pkg::ModePause;
        end else if (lk_mode == dmx_pkg::ModePause) begin
          tact = dmx_pkg::TimStop;
        end
      end
      dmx_pkg::ActRxStart: begin
        lk_rxlim = clamp_len(ev.len);
        lk_ptr   = 0;
        lk_mode  = dmx_pkg::ModePause;
        tact     = dmx_pkg::TimLoad;
        tval     = rxtmo_ticks;
      end
      dmx_pkg::ActRxByte, dmx_pkg::ActRxTmo: begin
        if (lk_mode == dmx_pkg::ModePause || lk_mode == dmx_pkg::ModeRecv) begin
          keep = 1'b1;
          if ((ev.action == dmx_pkg::ActRxByte && ev.berr) || ev.action == dmx_pkg::ActRxTmo ||
              lk_ptr >= lk_rxlim) begin
            lk_mode = dmx_pkg::ModePause;
            if (lk_ptr + 1 >= minf_reg) begin
              r.frame_done = 1'b1;
              r.frame_size = dmx_pkg::LenW'(lk_ptr + 1);
              lk_ptr       = 0;
              keep         = 1'b0;
            end else if (ev.action == dmx_pkg::ActRxTmo) begin
              keep = 1'b0;
            end
          end else if (lk_mode == dmx_pkg::ModePause) begin
            lk_mode = dmx_pkg::ModeRecv;
            lk_ptr  = 0;
          end else begin
            lk_ptr++;
          end
          // short frames keep the byte and rearm the silence timer
          if (keep) begin
            if (lk_ptr <= dmx_pkg::SlotCountDef) slot_mem[lk_ptr] = ev.data;
            tact = dmx_pkg::TimLoad;
            tval = rxtmo_ticks;
          end
        end
      end
      default: begin
        tact    = dmx_pkg::TimStop;
        lk_mode = dmx_pkg::ModePause;
      end
    endcase
    r.mode         = lk_mode;
    r.drive_out    = (lk_mode >= dmx_pkg::ModeBreak && lk_mode <= dmx_pkg::ModeMbb);
    r.line_level   = (lk_mode != dmx_pkg::ModeBreak);
    r.timer_action = tact;
    r.timer_value  = (tact == dmx_pkg::TimLoad) ? tval : '0;
    return r;
  endfunction

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always #(ClkPeriod / 2) clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycles <= cycles + 1;
    if (cycles > CycleLimit) begin
      $display("dmx512_frame_tx_rx_controller_top verification failed");
      $finish;
    end
  end

  // event words out
  always @(negedge clk_i) begin : drive_events
    link_event_t nxt;
    if (rst_ni && !(s_axis_tvalid && !s_fire)) begin
      if (in_gap > 0) begin
        in_gap        <= in_gap - 1;
        s_axis_tvalid <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        in_gap        <= $urandom_range(0, 4);
        s_axis_tvalid <= 1'b0;
      end else if (pend_q.size() > 0) begin
        nxt           = pend_q.pop_front();
        in_cur        <= nxt;
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= {3'b000, nxt.set_sc, nxt.len, nxt.data, nxt.slot};
        s_axis_tuser  <= {nxt.berr, nxt.action};
      end else begin
        s_axis_tvalid <= 1'b0;
      end
    end
  end

  always @(posedge clk_i) begin
    s_fire <= s_axis_tvalid && s_axis_tready;
    if (rst_ni && s_axis_tvalid && s_axis_tready) link_exp_q.push_back(link_step(in_cur));
  end

  always @(negedge clk_i) begin
    if (rst_ni) begin
      if (out_gap > 0) begin
        out_gap       <= out_gap - 1;
        m_axis_tready <= 1'b0;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        out_gap       <= $urandom_range(0, 4);
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= 1'b1;
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    link_result_t got;
    link_result_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      got = m_axis_tdata;
      if (link_exp_q.size() == 0) begin
        $error("result word with no expectation waiting");
        mismatches++;
      end else begin
        want = link_exp_q.pop_front();
        check_field("mode", want.mode, got.mode);
        check_field("drive_out", want.drive_out, got.drive_out);
        check_field("line_level", want.line_level, got.line_level);
        check_field("tx_valid", want.tx_valid, got.tx_valid);
        check_field("tx_data", want.tx_data, got.tx_data);
        check_field("timer_action", want.timer_action, got.timer_action);
        check_field("timer_value", want.timer_value, got.timer_value);
        check_field("frame_done", want.frame_done, got.frame_done);
        check_field("frame_size", want.frame_size, got.frame_size);
        check_field("read_data", want.read_data, got.read_data);
        check_field("zero_fill", want.zero_fill, got.zero_fill);
      end
    end
  end

  task automatic put(input logic [dmx_pkg::ActionW-1:0] act, input int unsigned slot,
                     input int unsigned dat, input int unsigned len,
                     input int unsigned sc, input int unsigned be);
    link_event_t ev;
    ev.action = act;
    ev.slot   = dmx_pkg::SlotW'(slot);
    ev.data   = dmx_pkg::ByteW'(dat);
    ev.len    = dmx_pkg::LenW'(len);
    ev.set_sc = sc[0];
    ev.berr   = be[0];
    pend_q.push_back(ev);
    queued++;
  endtask

  task automatic put_any(input logic [dmx_pkg::ActionW-1:0] act);
    put(act, $urandom, $urandom, $urandom, $urandom, $urandom);
  endtask

  task automatic write_reg(input logic [dmx_pkg::CfgIdxW-1:0] idx,
                           input logic [dmx_pkg::CfgDataW-1:0] val);
    @(negedge clk_i);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
    while (!cfg_ready_o) @(posedge clk_i);
    case (idx)
      dmx_pkg::CfgStartCode: sc_reg = val[dmx_pkg::ByteW-1:0];
      dmx_pkg::CfgMinFrame:  minf_reg = val[dmx_pkg::LenW-1:0];
      dmx_pkg::CfgBreak:     brk_ticks = val;
      dmx_pkg::CfgMab:       mab_ticks = val;
      dmx_pkg::CfgMbb:       mbb_ticks = val;
      dmx_pkg::CfgRxTmo:     rxtmo_ticks = val;
      default: ;
    endcase
    @(negedge clk_i);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic write_all(input logic [dmx_pkg::ByteW-1:0] sc,
                           input logic [dmx_pkg::LenW-1:0] minf,
                           input logic [dmx_pkg::TimeW-1:0] brk,
                           input logic [dmx_pkg::TimeW-1:0] mab,
                           input logic [dmx_pkg::TimeW-1:0] mbb,
                           input logic [dmx_pkg::TimeW-1:0] tmo);
    write_reg(dmx_pkg::CfgStartCode, {12'd0, sc});
    write_reg(dmx_pkg::CfgMinFrame, {10'd0, minf});
    write_reg(dmx_pkg::CfgBreak, brk);
    write_reg(dmx_pkg::CfgMab, mab);
    write_reg(dmx_pkg::CfgMbb, mbb);
    write_reg(dmx_pkg::CfgRxTmo, tmo);
  endtask

  // wait for every word to come back, then for the pipeline to empty
  task automatic settle();
    while (pend_q.size() != 0 || s_axis_tvalid || link_exp_q.size() != 0) @(posedge clk_i);
    repeat (4) @(posedge clk_i);
  endtask

  task automatic queue_tx_frame(input bit huge);
    logic [dmx_pkg::LenW-1:0] len;
    int unsigned              n;
    if (huge) len = ($urandom_range(0, 1) == 0) ? 10'd1023 : 10'd513;
    else if ($urandom_range(0, 7) == 0) len = '0;
    else len = dmx_pkg::LenW'($urandom_range(1, 12));
    put(dmx_pkg::ActTxStart, $urandom, $urandom, len, $urandom, $urandom);
    n = 3 + ((len == 0) ? 1 : clamp_len(len)) + $urandom_range(0, 1);
    // sometimes cut the frame short and let the next sequence take over
    if ($urandom_range(0, 7) == 0) n = $urandom_range(0, n);
    repeat (n) put_any(dmx_pkg::ActTxEvent);
  endtask

  task automatic queue_rx_frame();
    logic [dmx_pkg::LenW-1:0] lim;
    int unsigned              span;
    int unsigned              n;
    span = (minf_reg > 20) ? 26 : minf_reg + 6;
    if ($urandom_range(0, 9) == 0) lim = dmx_pkg::LenW'($urandom);
    else lim = dmx_pkg::LenW'($urandom_range(0, span));
    put(dmx_pkg::ActRxStart, $urandom, $urandom, lim, $urandom, $urandom);
    n = clamp_len(lim);
    n = $urandom_range(0, ((n > 30) ? 30 : n) + 2);
    repeat (n) begin
      put(dmx_pkg::ActRxByte, $urandom, $urandom, $urandom, $urandom,
          ($urandom_range(0, 11) == 0) ? 1 : 0);
    end
    case ($urandom_range(0, 3))
      0: put_any(dmx_pkg::ActRxTmo);
      1: put(dmx_pkg::ActRxByte, $urandom, $urandom, $urandom, $urandom, 1);
      2: put_any(dmx_pkg::ActStop);
      default: ;
    endcase
  endtask

  task automatic run_phase(input int unsigned count, input bit huge);
    int unsigned goal;
    goal = queued + count;
    if (huge) queue_tx_frame(1'b1);
    while (queued < goal) begin
      case ($urandom_range(0, 4))
        0, 1: queue_tx_frame(1'b0);
        2, 3: queue_rx_frame();
        default: begin
          repeat ($urandom_range(1, 3)) put_any(dmx_pkg::ActionW'($urandom_range(0, 7)));
        end
      endcase
    end
    settle();
  endtask

  initial begin
    clk_i         = 1'b0;
    rst_ni        = 1'b0;
    cfg_valid_i   = 1'b0;
    cfg_index_i   = '0;
    cfg_data_i    = '0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = '0;
    m_axis_tready = 1'b0;
    in_cur        = '0;
    s_fire        = 1'b0;
    in_gap        = 0;
    out_gap       = 0;
    calm          = 1'b0;
    mismatches    = 0;
    cycles        = 0;
    queued        = 0;
    for (int i = 0; i <= dmx_pkg::SlotCountDef; i++) slot_mem[i] = '0;
    repeat (ResetCycles) @(negedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    write_all(8'hA5, 10'd2, 20'd0, 20'hFFFFF, 20'd0, 20'd1);
    write_reg(CfgSpare, 20'hFFFFF);

    // give every slot a value so no read ever hits an unwritten one
    for (int i = 0; i <= dmx_pkg::SlotCountDef; i++) begin
      put(dmx_pkg::ActWrSlot, i, $urandom, $urandom, $urandom, $urandom);
    end

    // nothing is running yet: line events do nothing
    put(dmx_pkg::ActTxEvent, 0, 0, 0, 0, 0);
    put(dmx_pkg::ActRxByte, 0, 8'hFF, 0, 0, 1);
    put(dmx_pkg::ActRxTmo, 10'h3FF, 8'hFF, 10'h3FF, 1, 1);
    // slots past the end, and the last slot
    put(dmx_pkg::ActWrSlot, 513, 8'h5A, 0, 0, 0);
    put(dmx_pkg::ActWrSlot, 1023, 8'hFF, 1023, 1, 1);
    put(dmx_pkg::ActRdSlot, 1023, 0, 0, 0, 0);
    put(dmx_pkg::ActRdSlot, 512, 0, 0, 0, 0);
    // zero length transmit with the start code forced, walked to pause and beyond
    put(dmx_pkg::ActTxStart, 0, 0, 0, 1, 0);
    repeat (5) put(dmx_pkg::ActTxEvent, 0, 0, 0, 0, 0);
    put(dmx_pkg::ActRdSlot, 0, 0, 0, 0, 0);
    // overlong transmit, then a receive started in mid transmit
    put(dmx_pkg::ActTxStart, 0, 0, 1023, 0, 0);
    put(dmx_pkg::ActTxEvent, 0, 0, 0, 0, 0);
    put(dmx_pkg::ActRxStart, 0, 0, 1, 0, 0);
    put(dmx_pkg::ActRxByte, 0, 8'h00, 0, 0, 0);
    put(dmx_pkg::ActRxByte, 0, 8'hFF, 0, 0, 0);
    put(dmx_pkg::ActRxByte, 0, 8'h3C, 0, 0, 0);
    put(dmx_pkg::ActRxByte, 0, 8'h81, 0, 0, 1);
    put(dmx_pkg::ActRxTmo, 0, 0, 0, 0, 0);
    put(dmx_pkg::ActStop, 0, 0, 0, 0, 0);
    put(dmx_pkg::ActRxStart, 0, 0, 0, 0, 0);
    put(dmx_pkg::ActRxByte, 0, 8'h42, 0, 0, 0);
    put(dmx_pkg::ActRdSlot, 0, 0, 0, 0, 0);
    settle();

    write_all(8'h00, 10'd1, 20'hFFFFF, 20'd0, 20'hFFFFF, 20'd0);
    run_phase(120, 1'b0);

    write_all(8'hFF, 10'd513, dmx_pkg::TimeW'($urandom), dmx_pkg::TimeW'($urandom),
              dmx_pkg::TimeW'($urandom), 20'hFFFFF);
    run_phase(120, 1'b0);

    write_all(dmx_pkg::ByteW'($urandom), dmx_pkg::LenW'($urandom_range(2, 8)),
              dmx_pkg::TimeW'($urandom), dmx_pkg::TimeW'($urandom),
              dmx_pkg::TimeW'($urandom), dmx_pkg::TimeW'($urandom));
    run_phase(140, 1'b0);

    calm = 1'b1;
    write_all(dmx_pkg::ByteW'($urandom), dmx_pkg::LenW'($urandom_range(2, 30)),
              dmx_pkg::BreakRst, dmx_pkg::MabRst, dmx_pkg::MbbRst, dmx_pkg::RxTmoRst);
    run_phase(120, 1'b0);

    repeat (10) @(posedge clk_i);
    if (mismatches == 0 && link_exp_q.size() == 0) begin
      $display("dmx512_frame_tx_rx_controller_top verification clean");
    end else begin
      $display("dmx512_frame_tx_rx_controller_top verification failed");
    end
    $finish;
  end

endmodule

// ----- files.f -----
design/dmx_pkg.sv
design/dmx512_frame_tx_rx_controller_top.sv
sim/tb.sv
